/* rtl/lams_pkg.sv */
// Package: shared constants, codes and types of the light animation mode sequencer.
`default_nettype none
package lams_pkg;

    localparam int GROUP_COUNT      = 16;
    localparam int LED_STATE_COUNT  = 8;
    localparam int BULB_STATE_COUNT = 4;
    localparam int GRP_W            = $clog2(GROUP_COUNT);

    // event codes
    localparam logic [2:0] EV_NEXT_ANIM  = 3'd0;
    localparam logic [2:0] EV_NEXT_MODE  = 3'd1;
    localparam logic [2:0] EV_TOGGLE     = 3'd2;
    localparam logic [2:0] EV_PEER       = 3'd3;
    localparam logic [2:0] EV_BCAST_DONE = 3'd4;
    localparam logic [2:0] EV_TICK       = 3'd5;

    // operating modes
    localparam logic [1:0] OPM_NETWORK    = 2'd0;
    localparam logic [1:0] OPM_INDIVIDUAL = 2'd1;
    localparam logic [1:0] OPM_OPEN_PIXEL = 2'd2;

    // register indexes
    localparam logic [2:0] REG_DEVICE_KIND = 3'd0;
    localparam logic [2:0] REG_OWN_GROUP   = 3'd1;
    localparam logic [2:0] REG_ADV_DELAY   = 3'd2;
    localparam logic [2:0] REG_SHOW_ANIM   = 3'd3;
    localparam logic [2:0] REG_SHOW_MODE   = 3'd4;
    localparam logic [2:0] REG_DISABLING   = 3'd5;
    localparam logic [2:0] REG_ENABLING    = 3'd6;

    typedef struct packed {
        logic             en;
        logic [GRP_W-1:0] addr;
        logic [7:0]       data;
    } tbl_wr_t;

endpackage
`default_nettype wire

/* rtl/lams_table.sv */
// Group state table: synchronous memory with valid bits and write-to-read forwarding.
`default_nettype none
module lams_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [lams_pkg::GRP_W-1:0]  rd_addr,
    input  wire lams_pkg::tbl_wr_t           wr,
    output logic [7:0]                       rd_data
);

    logic [7:0]                      mem [lams_pkg::GROUP_COUNT];
    logic [7:0]                      mem_rd_reg;
    logic [lams_pkg::GROUP_COUNT-1:0] valid_reg;
    logic                            vld_rd_reg;
    logic                            fwd_hit_reg;
    logic [7:0]                      fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            vld_rd_reg   <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            fwd_data_reg <= 8'd0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_rd_reg   <= valid_reg[rd_addr];
                // a write landing on the read address in the same edge wins
                fwd_hit_reg  <= wr.en && (wr.addr == rd_addr);
                fwd_data_reg <= wr.data;
            end
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : (vld_rd_reg ? mem_rd_reg : 8'd0);

endmodule
`default_nettype wire

/* rtl/light_animation_mode_sequencer.sv */
// A result is presented on the master side from the output register, after its item has passed
// the input stage; a stall on the master side holds the item in the input stage.
// Throughput: one item per cycle unless the master side stalls; the read-modify-write of
// the group table in lams_table keeps that rate by forwarding a write to the own-group read.
// Reset: all state to its reset values (lit set, network mode), registers to defaults,
// table valid bits cleared so every group reads zero; no clearing pass.
`default_nettype none
module light_animation_mode_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // now_ms[31:0], peer_group[35:32], peer_state[43:36]
    input  wire logic [2:0]  s_tuser,   // event[2:0]
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // changed[0], shown_index[8:1], pending_index[16:9],
                                        // op_mode[18:17], lit[19], advancing[20],
                                        // broadcast_needed[21]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic        device_kind_reg;
    logic [3:0]  own_group_reg;
    logic [31:0] adv_delay_reg;
    logic [7:0]  show_anim_reg;
    logic [7:0]  show_mode_reg;
    logic [7:0]  disabling_reg;
    logic [7:0]  enabling_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_kind_reg <= 1'b0;
            own_group_reg   <= 4'd0;
            adv_delay_reg   <= 32'd1000;
            show_anim_reg   <= 8'd252;
            show_mode_reg   <= 8'd253;
            disabling_reg   <= 8'd254;
            enabling_reg    <= 8'd255;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                lams_pkg::REG_DEVICE_KIND: device_kind_reg <= pwdata[0];
                lams_pkg::REG_OWN_GROUP:   own_group_reg   <= pwdata[3:0];
                lams_pkg::REG_ADV_DELAY:   adv_delay_reg   <= pwdata;
                lams_pkg::REG_SHOW_ANIM:   show_anim_reg   <= pwdata[7:0];
                lams_pkg::REG_SHOW_MODE:   show_mode_reg   <= pwdata[7:0];
                lams_pkg::REG_DISABLING:   disabling_reg   <= pwdata[7:0];
                lams_pkg::REG_ENABLING:    enabling_reg    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            lams_pkg::REG_DEVICE_KIND: prdata = {31'd0, device_kind_reg};
            lams_pkg::REG_OWN_GROUP:   prdata = {28'd0, own_group_reg};
            lams_pkg::REG_ADV_DELAY:   prdata = adv_delay_reg;
            lams_pkg::REG_SHOW_ANIM:   prdata = {24'd0, show_anim_reg};
            lams_pkg::REG_SHOW_MODE:   prdata = {24'd0, show_mode_reg};
            lams_pkg::REG_DISABLING:   prdata = {24'd0, disabling_reg};
            lams_pkg::REG_ENABLING:    prdata = {24'd0, enabling_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // input stage
    logic        s1_valid_reg;
    logic [2:0]  s1_ev_reg;
    logic [31:0] s1_now_reg;
    logic [3:0]  s1_pg_reg;
    logic [7:0]  s1_ps_reg;
    logic        in_acc;
    logic        commit;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    assign in_acc   = s_tvalid && s_tready;
    assign commit   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ev_reg  <= s_tuser;
            s1_now_reg <= s_tdata[31:0];
            s1_pg_reg  <= s_tdata[35:32];
            s1_ps_reg  <= s_tdata[43:36];
        end
    end

    // group table; the only read address is the own group
    lams_pkg::tbl_wr_t tbl_wr;
    logic [7:0]        tbl_rd;

    lams_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (own_group_reg[lams_pkg::GRP_W-1:0]),
        .wr      (tbl_wr),
        .rd_data (tbl_rd)
    );

    // scalar state
    logic [7:0]  shown_reg,    shown_next;
    logic [7:0]  pending_reg,  pending_next;
    logic [31:0] deadline_reg, deadline_next;
    logic        adv_reg,      adv_next;
    logic        dis_after_reg, dis_after_next;
    logic        lit_reg,      lit_next;
    logic [1:0]  opm_reg,      opm_next;
    logic        bcast_reg,    bcast_next;
    logic        changed;

    logic [7:0]  base;
    logic [7:0]  inc;
    logic [8:0]  limit;
    logic        own_in_tbl;
    logic        pg_in_tbl;
    logic        tick_fire;
    logic        lit_after;

    always_comb
    begin
        base       = adv_reg ? pending_reg : shown_reg;
        inc        = base + 8'd1;
        limit      = device_kind_reg ? 9'(lams_pkg::BULB_STATE_COUNT)
                                     : 9'(lams_pkg::LED_STATE_COUNT);
        own_in_tbl = ({1'b0, own_group_reg} < 5'(lams_pkg::GROUP_COUNT));
        pg_in_tbl  = ({1'b0, s1_pg_reg} < 5'(lams_pkg::GROUP_COUNT));
        tick_fire  = adv_reg && (deadline_reg <= s1_now_reg);
        lit_after  = lit_reg && !dis_after_reg;

        shown_next     = shown_reg;
        pending_next   = pending_reg;
        deadline_next  = deadline_reg;
        adv_next       = adv_reg;
        dis_after_next = dis_after_reg;
        lit_next       = lit_reg;
        opm_next       = opm_reg;
        bcast_next     = bcast_reg;
        changed        = 1'b0;
        tbl_wr.en      = 1'b0;
        tbl_wr.addr    = own_group_reg[lams_pkg::GRP_W-1:0];
        tbl_wr.data    = show_anim_reg;

        unique case (s1_ev_reg)
            lams_pkg::EV_NEXT_ANIM:
            begin
                // wrap to zero at the state count of the device kind
                pending_next  = ({1'b0, inc} >= limit) ? 8'd0 : inc;
                adv_next      = 1'b1;
                deadline_next = s1_now_reg + adv_delay_reg;
                shown_next    = show_anim_reg;
                if (opm_reg == lams_pkg::OPM_NETWORK)
                begin
                    tbl_wr.en  = own_in_tbl;
                    bcast_next = 1'b1;
                end
                changed = 1'b1;
            end
            lams_pkg::EV_NEXT_MODE:
            begin
                shown_next    = show_mode_reg;
                adv_next      = 1'b1;
                deadline_next = s1_now_reg + adv_delay_reg;
                if (opm_reg == lams_pkg::OPM_NETWORK)
                begin
                    opm_next     = lams_pkg::OPM_INDIVIDUAL;
                    pending_next = base;
                end
                else if (opm_reg == lams_pkg::OPM_INDIVIDUAL)
                begin
                    opm_next     = lams_pkg::OPM_OPEN_PIXEL;
                    pending_next = 8'd0;
                end
                else
                begin
                    opm_next     = lams_pkg::OPM_NETWORK;
                    pending_next = own_in_tbl ? tbl_rd : 8'd0;
                end
                changed = 1'b1;
            end
            lams_pkg::EV_TOGGLE:
            begin
                pending_next  = base;
                adv_next      = 1'b1;
                deadline_next = s1_now_reg + adv_delay_reg;
                if (lit_reg)
                begin
                    shown_next     = disabling_reg;
                    dis_after_next = 1'b1;
                end
                else
                begin
                    shown_next     = enabling_reg;
                    dis_after_next = 1'b0;
                    lit_next       = 1'b1;
                end
                changed = 1'b1;
            end
            lams_pkg::EV_PEER:
            begin
                tbl_wr.en   = pg_in_tbl;
                tbl_wr.addr = s1_pg_reg[lams_pkg::GRP_W-1:0];
                tbl_wr.data = s1_ps_reg;
                if (opm_reg == lams_pkg::OPM_NETWORK && own_group_reg == s1_pg_reg)
                begin
                    adv_next   = 1'b0;
                    shown_next = s1_ps_reg;
                end
                changed = 1'b1;
            end
            lams_pkg::EV_BCAST_DONE:
            begin
                bcast_next = 1'b0;
                changed    = 1'b1;
            end
            lams_pkg::EV_TICK:
            begin
                if (tick_fire)
                begin
                    shown_next     = pending_reg;
                    adv_next       = 1'b0;
                    dis_after_next = 1'b0;
                    lit_next       = lit_after;
                    if (opm_reg == lams_pkg::OPM_NETWORK && lit_after)
                    begin
                        tbl_wr.en   = own_in_tbl;
                        tbl_wr.data = pending_reg;
                        bcast_next  = 1'b1;
                    end
                    changed = 1'b1;
                end
            end
            default: ;
        endcase

        if (!commit)
        begin
            tbl_wr.en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg     <= 8'd0;
            pending_reg   <= 8'd0;
            deadline_reg  <= 32'd0;
            adv_reg       <= 1'b0;
            dis_after_reg <= 1'b0;
            lit_reg       <= 1'b1;
            opm_reg       <= lams_pkg::OPM_NETWORK;
            bcast_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                shown_reg     <= shown_next;
                pending_reg   <= pending_next;
                deadline_reg  <= deadline_next;
                adv_reg       <= adv_next;
                dis_after_reg <= dis_after_next;
                lit_reg       <= lit_next;
                opm_reg       <= opm_next;
                bcast_reg     <= bcast_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg <= {2'b00, bcast_next, adv_next, lit_next, opm_next,
                             pending_next, shown_next, changed};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // the table is only written by an item that is leaving the stage
    a_tbl_wr_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |-> commit)
        else $error("table written without commit");

    // a committed item always shows up on the master side next cycle
    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> m_tvalid)
        else $error("committed item not presented");

    // the device only turns off through a tick
    a_lit_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(lit_reg) |-> $past(commit && s1_ev_reg == lams_pkg::EV_TICK))
        else $error("lit cleared outside a tick");

    // a firing tick ends the advance
    a_tick_ends_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && s1_ev_reg == lams_pkg::EV_TICK && tick_fire) |=> !adv_reg)
        else $error("advance still pending after tick");
`endif

endmodule
`default_nettype wire
